### rtl/lcgb_pkg.sv
// Shared types and constants for the bounded minimal standard generator.
// Holds the sequencer state type, register indexes, generator constants and
// the built-in seed table. No dependencies.
package lcgb_pkg;

    // Generator constants: multiplier and modulus 2^31 - 1
    localparam logic [14:0] LCG_MUL = 15'd16807;
    localparam logic [30:0] LCG_MOD = 31'h7FFF_FFFF;

    // Largest legal bound for a bounded draw
    localparam logic [31:0] BOUND_MAX = 32'd2147483646;

    // Seed table size and default usable depth
    localparam int SEED_TABLE_SIZE = 256;
    localparam int SEED_TABLE_DEPTH_DEFAULT = 256;

    // Configuration register indexes
    localparam logic [1:0] REG_USE_TABLE_SEED   = 2'd0;
    localparam logic [1:0] REG_TABLE_SEED_INDEX = 2'd1;
    localparam logic [1:0] REG_EXPLICIT_SEED    = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_RED,
        ST_CHK,
        ST_ERR
    } lcgb_state_t;

    // Built-in seed table
    localparam logic [30:0] SEED_TABLE [SEED_TABLE_SIZE] = '{
        1, 1331238991, 1550655590, 930627303, 766698560, 372156336,
        1645116277, 1635860990, 1154667137, 692982627, 1961833381,
        713190994, 460575272, 1298018763, 1497719440, 2030952567,
        901595110, 631930165, 354421844, 1213737427, 1800697079,
        795809157, 821079954, 1624537871, 1918430133, 861482464,
        1736896562, 1220028201, 634729389, 456922549, 23246132,
        979545543, 1008653149, 1156436224, 1689665648, 1604778030,
        1628735393, 1949577498, 550023088, 1726571906, 1267216792,
        1750609806, 314116942, 736299588, 2095003524, 1281569003,
        356484144, 1423591576, 2140958617, 1577658393, 1116852912,
        1865734753, 1701937813, 301264580, 171817360, 1809513683,
        360646631, 546534802, 1652205397, 136501886, 605448579,
        1857604347, 1223969344, 668104522, 1821072732, 738721927,
        1237280745, 1753702432, 2125855022, 1259255700, 935058038,
        1325807218, 1151620124, 585222105, 1970906347, 1267057970,
        66562942, 1959090863, 1503754591, 114059398, 2007872839,
        1886985293, 1870986444, 2110445215, 1375265396, 1512926254,
        470646700, 1951555990, 500432100, 1843528576, 347147950,
        1431668171, 929595364, 1507452793, 800443847, 1428656866,
        5715478, 1607979231, 2032092669, 37809413, 996425830,
        1010869813, 1884232020, 312192738, 1821061493, 462270727,
        248900140, 678804905, 905130946, 1892339752, 1307421505,
        491642575, 1091346202, 1076664921, 1140141037, 122447008,
        1244153851, 1382627577, 611793617, 1989326495, 808278095,
        1352281487, 2106046913, 1731628906, 1226683843, 1683200486,
        90274853, 1676390615, 2147466840, 498396356, 2140522509,
        1217803227, 1146667727, 788324559, 1530171233, 317473611,
        319146380, 992289339, 2077765218, 652681396, 789950931,
        485020132, 632682054, 32775496, 1683083109, 603834907,
        351704670, 1809710911, 171230418, 1511135464, 1986612391,
        1646573708, 1411714374, 1546459273, 872179784, 1307370996,
        801917373, 2051724276, 144283230, 1535180348, 1949917822,
        650872229, 113201992, 890256110, 1965781805, 1903960687,
        679060319, 452497769, 630187802, 174438105, 1298843779,
        961082145, 1565131991, 2078229636, 50366922, 959177042,
        144513213, 1423462005, 207666443, 152219823, 13354949,
        412643566, 631135695, 166938633, 958408264, 1324624652,
        494931978, 1472820641, 1150735880, 1508483704, 1640573652,
        359288909, 1315013967, 1051019865, 1254156333, 1883764098,
        587564032, 1288274932, 1912367727, 1595891993, 2138169990,
        1794668172, 2059764593, 1152025509, 115613893, 926625010,
        131630606, 706594585, 1386707532, 1624163092, 2081362360,
        1882152641, 1428465736, 602313149, 1170668648, 863700348,
        931140599, 1856765731, 197473249, 507314638, 1381732824,
        252975355, 925311926, 1726193892, 576725369, 774762078,
        198434005, 192355221, 1296038143, 1201667973, 653782169,
        1426685702, 1503907840, 211726157, 33491376, 906578176,
        238345926, 1826083853, 1366925216, 480315631, 1549695660,
        1337366022, 1793656969, 1469954017, 1701980729, 98857548,
        1883864564, 1709982325, 251608257, 1171967839, 642486710,
        1358844649, 1115145546, 1398997376, 1021484058, 2035865982
    };

endpackage

### rtl/minimal_standard_lcg_bounded.sv
// Top level of the bounded minimal standard generator: seed register,
// one shared multiply and modular fold unit, and the draw sequencer.
// Depends on lcgb_pkg.
//
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      tdata: bound[31:0]; tuser: mode
// m_*       out  tvalid/tready      tdata: value[30:0], zero pad; tuser: error
// cfg_*     in   cfg_we only        cfg_index selects register, cfg_data value
//
// An item is accepted only in the idle state; the block is busy until its
// result has been loaded into the output register.
// A draw uses the shared unit for a multiply, then a fold modulo 2^31 - 1,
// with the range check overlapped on the next multiply.
// A raw draw passes the multiply, fold and check states; a bounded draw
// repeats fold and check per rejected value; an illegal bound skips to the error state.
// Reset loads the seed from table entry zero; no clearing pass is needed.
// A stalled output holds the finished result; one further beat is still
// taken and waits with its finished result in the check state (the error
// state for an illegal bound), after which s_tready stays low until the output beat is taken.
module minimal_standard_lcg_bounded
    import lcgb_pkg::*;
#(
    parameter int SEED_TABLE_DEPTH = SEED_TABLE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] bound
    input  logic        s_tuser,   // [0] mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [30:0] value, [31] zero
    output logic        m_tuser,   // [0] error
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [30:0] cfg_data
);

    lcgb_state_t state_reg, state_next;

    logic        use_table_reg,    use_table_next;
    logic [7:0]  table_index_reg,  table_index_next;
    logic [30:0] explicit_seed_reg, explicit_seed_next;
    logic [30:0] seed_reg,  seed_next;
    logic [45:0] prod_reg,  prod_next;
    logic [30:0] mask_reg,  mask_next;
    logic [30:0] bound_reg, bound_next;
    logic        out_valid_reg, out_valid_next;
    logic [30:0] out_value_reg, out_value_next;
    logic        out_error_reg, out_error_next;

    logic [7:0]  wrap_lut [SEED_TABLE_SIZE];
    logic        cfg_hit;
    logic [30:0] load_seed;
    logic [30:0] smear;
    logic [31:0] fold_sum;
    logic [30:0] fold_res;
    logic [30:0] cand;
    logic        pass;
    logic        out_free;
    logic        bound_bad;

    // Table index wrap, worked out per entry at elaboration
    for (genvar g = 0; g < SEED_TABLE_SIZE; g++)
    begin : g_wrap
        assign wrap_lut[g] = 8'(g % SEED_TABLE_DEPTH);
    end

    // Seed reload value, taken from the register values after this write
    always_comb
    begin
        if (use_table_next)
        begin
            load_seed = SEED_TABLE[wrap_lut[table_index_next]];
        end
        else if (explicit_seed_next == '0 || explicit_seed_next == LCG_MOD)
        begin
            load_seed = 31'd1;
        end
        else
        begin
            load_seed = explicit_seed_next;
        end
    end

    // Configuration register writes
    always_comb
    begin
        use_table_next     = use_table_reg;
        table_index_next   = table_index_reg;
        explicit_seed_next = explicit_seed_reg;
        cfg_hit            = 1'b0;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_USE_TABLE_SEED:
                begin
                    use_table_next = cfg_data[0];
                    cfg_hit        = 1'b1;
                end
                REG_TABLE_SEED_INDEX:
                begin
                    table_index_next = cfg_data[7:0];
                    cfg_hit          = 1'b1;
                end
                REG_EXPLICIT_SEED:
                begin
                    explicit_seed_next = cfg_data;
                    cfg_hit            = 1'b1;
                end
                default:
                begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // Mask of the bits used by bound - 1
    always_comb
    begin
        smear = s_tdata[30:0] - 31'd1;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
    end

    // Fold of the 46-bit product modulo 2^31 - 1
    assign fold_sum = {1'b0, prod_reg[30:0]} + {17'd0, prod_reg[45:31]};
    assign fold_res = (fold_sum >= {1'b0, LCG_MOD}) ? 31'(fold_sum - {1'b0, LCG_MOD})
                                                    : fold_sum[30:0];

    // Candidate value and its range check
    assign cand      = (seed_reg - 31'd1) & mask_reg;
    assign pass      = cand < bound_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign bound_bad = (s_tdata == '0) || (s_tdata > BOUND_MAX);

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        seed_next      = seed_reg;
        prod_next      = prod_reg;
        mask_next      = mask_reg;
        bound_next     = bound_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_value_next = out_value_reg;
        out_error_next = out_error_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser && bound_bad)
                    begin
                        state_next = ST_ERR;
                    end
                    else
                    begin
                        mask_next  = s_tuser ? smear : '1;
                        bound_next = s_tuser ? s_tdata[30:0] : '1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                prod_next  = 46'(seed_reg) * 46'(LCG_MUL);
                state_next = ST_RED;
            end
            ST_RED:
            begin
                seed_next  = fold_res;
                state_next = ST_CHK;
            end
            ST_CHK:
            begin
                // The next multiply runs alongside the check
                prod_next = 46'(seed_reg) * 46'(LCG_MUL);
                if (!pass)
                begin
                    state_next = ST_RED;
                end
                else if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cand;
                    out_error_next = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            ST_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = '0;
                    out_error_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Any register write reloads the seed
        if (cfg_hit)
        begin
            seed_next = load_seed;
        end
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            use_table_reg     <= 1'b1;
            table_index_reg   <= '0;
            explicit_seed_reg <= 31'd1;
            seed_reg          <= SEED_TABLE[0];
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            use_table_reg     <= use_table_next;
            table_index_reg   <= table_index_next;
            explicit_seed_reg <= explicit_seed_next;
            seed_reg          <= seed_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        prod_reg      <= prod_next;
        mask_reg      <= mask_next;
        bound_reg     <= bound_next;
        out_value_reg <= out_value_next;
        out_error_reg <= out_error_next;
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_value_reg};
    assign m_tuser  = out_error_reg;

endmodule

### rtl/lcgb_checker.sv
// Port-level checker for the bounded minimal standard generator, and the
// bind that attaches it to the top level. Uses no package.
module lcgb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tuser
);

    logic        bounded_reg;
    logic [31:0] bound_reg;
    logic        held_reg;

    // Remember the kind and bound of the last accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bounded_reg <= 1'b0;
            bound_reg   <= '0;
        end
        else if (s_tvalid && s_tready)
        begin
            bounded_reg <= s_tuser;
            bound_reg   <= s_tdata;
        end
    end

    // Note whether the result beat on show was already there last cycle.
    // A fresh result always belongs to the last accepted beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg <= 1'b0;
        end
        else
        begin
            held_reg <= m_tvalid && !m_tready;
        end
    end

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // The block is busy right after taking a beat
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted again without drawing");

    // An error result carries a zero value, and values stay in range
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[31] == 1'b0 && m_tdata[30:1] != 30'h3FFF_FFFF
                     && (!m_tuser || m_tdata == 32'd0))
        else $error("result value out of range");

    // A fresh bounded draw lands below its bound
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !held_reg && !m_tuser && bounded_reg |-> m_tdata < bound_reg)
        else $error("bounded draw not below bound");

endmodule

bind minimal_standard_lcg_bounded lcgb_checker u_lcgb_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

### verif/tb_top.sv
// Self-checking bench for the bounded minimal standard generator.
// Contains a tracker class that predicts each draw and checks it, plus stimulus tasks.
// Depends on lcgb_pkg and minimal_standard_lcg_bounded.
module tb_top;
    import lcgb_pkg::*;

    // Unused register index: a write there must not reload the seed
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // Request kinds carried on s_tuser
    localparam logic MODE_RAW     = 1'b0;
    localparam logic MODE_BOUNDED = 1'b1;

    typedef struct packed {
        logic [31:0] data;
        logic        error;
    } draw_t;

    // Keeps a copy of the registers and the seed and predicts every draw.
    class draw_tracker;
        bit          use_table;
        logic [7:0]  table_index;
        logic [30:0] explicit_seed;
        logic [30:0] seed;
        draw_t       expected_draws[$];
        int          mismatches;

        function new();
            use_table     = 1'b1;
            table_index   = 8'd0;
            explicit_seed = 31'd1;
            mismatches    = 0;
            reload_seed();
        endfunction

        // A seed of zero or of the modulus would lock the sequence, so it loads as one.
        function void reload_seed();
            logic [30:0] s;
            if (use_table)
            begin
                seed = SEED_TABLE[table_index];
            end
            else
            begin
                s = explicit_seed;
                if (s == 31'd0 || s == LCG_MOD)
                    s = 31'd1;
                seed = s;
            end
        endfunction

        // One generator step by a full-width product; returns the new seed less one.
        function logic [30:0] step_seed();
            logic [63:0] prod;
            prod = 64'(seed) * 64'(LCG_MUL);
            seed = 31'(prod % 64'(LCG_MOD));
            return seed - 31'd1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [30:0] data);
            case (idx)
                REG_USE_TABLE_SEED:   use_table = data[0];
                REG_TABLE_SEED_INDEX: table_index = data[7:0];
                REG_EXPLICIT_SEED:    explicit_seed = data;
                default:              return;
            endcase
            reload_seed();
        endfunction

        // An illegal bound gives the error flag and leaves the seed alone.
        function void note_request(logic mode, logic [31:0] bound);
            draw_t       d;
            logic [31:0] span;
            logic [30:0] v;
            d.error = 1'b0;
            if (mode == MODE_RAW)
            begin
                v = step_seed();
            end
            else if (bound == 32'd0 || bound > BOUND_MAX)
            begin
                d.error = 1'b1;
                v = 31'd0;
            end
            else
            begin
                span = 32'd0;
                for (int i = 0; i < 32; i++)
                    if (((bound - 32'd1) >> i) != 32'd0)
                        span[i] = 1'b1;
                do
                    v = step_seed() & span[30:0];
                while ({1'b0, v} >= bound);
            end
            d.data = {1'b0, v};
            expected_draws.push_back(d);
        endfunction

        function void complain(string what, draw_t want, draw_t got);
            mismatches++;
            if (mismatches <= 10)
                $display("Draw mismatch (%s): expected value 0x%08h error %0b, got 0x%08h error %0b",
                         what, want.data, want.error, got.data, got.error);
        endfunction

        function void check_draw(logic [31:0] data, logic error);
            draw_t want;
            draw_t got;
            got.data  = data;
            got.error = error;
            if (expected_draws.size() == 0)
            begin
                complain("no draw pending", '0, got);
                return;
            end
            want = expected_draws.pop_front();
            if (data !== want.data)
                complain("value", want, got);
            if (error !== want.error)
                complain("error flag", want, got);
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] bound
    logic        s_tuser;    // [0] mode
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // [30:0] value, [31] zero
    logic        m_tuser;    // [0] error
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    draw_tracker tracker;
    logic        hold_req;
    int          burst_left;

    minimal_standard_lcg_bounded dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Overall time limit, many times the slowest legal run.
    initial
    begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

    // Every accepted result beat is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            tracker.check_draw(m_tdata, m_tuser);
    end

    // Receiver: segments with their own stall rate, plus a long hold-off on request.
    initial
    begin
        int seg_left;
        int stall_pct;
        seg_left  = 0;
        stall_pct = 0;
        m_tready  = 1'b0;
        hold_req  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                m_tready = 1'b0;
                repeat (99) @(negedge clk);
            end
            else
            begin
                if (seg_left == 0)
                begin
                    seg_left = $urandom_range(4, 40);
                    case ($urandom_range(0, 4))
                        0, 1:    stall_pct = 0;
                        2:       stall_pct = 30;
                        3:       stall_pct = 60;
                        default: stall_pct = 90;
                    endcase
                end
                seg_left--;
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    // Offers one request beat from a falling edge and returns at the falling edge
    // after it has been accepted.
    task automatic send_draw(input logic mode, input logic [31:0] bound);
        s_tuser  = mode;
        s_tdata  = bound;
        s_tvalid = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_request(mode, bound);
        @(negedge clk);
    endtask

    // Ends a burst now and then with a random gap before the next one.
    task automatic pace_sender();
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 3) != 0)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
        end
    endtask

    // Waits until every predicted draw has arrived and the block has settled.
    task automatic drain();
        s_tvalid = 1'b0;
        while (tracker.expected_draws.size() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    // Writes one register; must be called at a falling edge with the block idle.
    task automatic write_reg(input logic [1:0] idx, input logic [30:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 15))
            0:       return 32'd0;
            1:       return $urandom;
            2:       return BOUND_MAX + $urandom_range(1, 3);
            3:       return BOUND_MAX;
            4, 5:    return $urandom_range(1, 16);
            6, 7:    return (32'd1 << $urandom_range(0, 30)) + 32'd1;
            8:       return 32'd1 << $urandom_range(0, 30);
            9:       return (32'd1 << $urandom_range(1, 31)) - 32'd1;
            default: return $urandom_range(1, BOUND_MAX);
        endcase
    endfunction

    function automatic logic [30:0] pick_reg_data();
        case ($urandom_range(0, 7))
            0:       return 31'd0;
            1:       return 31'h7FFF_FFFF;
            2:       return 31'h7FFF_FFFE;
            3:       return 31'd1;
            4:       return 31'($urandom_range(0, 255));
            default: return 31'($urandom);
        endcase
    endfunction

    initial
    begin
        int failures;
        tracker    = new();
        burst_left = 0;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = 32'd0;
        s_tuser    = MODE_RAW;
        cfg_we     = 1'b0;
        cfg_index  = REG_USE_TABLE_SEED;
        cfg_data   = 31'd0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed draws from the reset seed: bound extremes, illegal bounds, raw mode.
        send_draw(MODE_RAW, 32'd0);
        send_draw(MODE_RAW, 32'hFFFF_FFFF);
        send_draw(MODE_BOUNDED, 32'd1);
        send_draw(MODE_BOUNDED, 32'd2);
        send_draw(MODE_BOUNDED, 32'd0);
        send_draw(MODE_BOUNDED, BOUND_MAX);
        send_draw(MODE_BOUNDED, BOUND_MAX + 32'd1);
        send_draw(MODE_BOUNDED, 32'hFFFF_FFFF);
        send_draw(MODE_BOUNDED, 32'h8000_0000);
        send_draw(MODE_BOUNDED, 32'd3);
        send_draw(MODE_BOUNDED, 32'h4000_0001);
        send_draw(MODE_BOUNDED, 32'h4000_0000);
        send_draw(MODE_BOUNDED, 32'h5555_5555);
        send_draw(MODE_BOUNDED, 32'hAAAA_AAAA);
        send_draw(MODE_BOUNDED, BOUND_MAX - 32'd1);
        drain();

        // Explicit seeding, including the two degenerate seeds and the largest legal one.
        write_reg(REG_USE_TABLE_SEED, 31'd0);
        send_draw(MODE_RAW, 32'd0);
        drain();
        write_reg(REG_EXPLICIT_SEED, 31'd0);
        send_draw(MODE_RAW, 32'd0);
        send_draw(MODE_BOUNDED, 32'd10);
        drain();
        write_reg(REG_EXPLICIT_SEED, 31'h7FFF_FFFF);
        send_draw(MODE_RAW, 32'd0);
        drain();
        write_reg(REG_EXPLICIT_SEED, 31'h7FFF_FFFE);
        send_draw(MODE_RAW, 32'd0);
        send_draw(MODE_BOUNDED, 32'd1000);
        drain();

        // A write to the unused index must leave the sequence running on.
        write_reg(REG_UNUSED, 31'h1234_5678);
        send_draw(MODE_RAW, 32'd0);
        drain();

        // Table seeding: last entry, wide data with only the low byte kept, bit 0 only.
        write_reg(REG_TABLE_SEED_INDEX, 31'd255);
        write_reg(REG_USE_TABLE_SEED, 31'h7FFF_FFFF);
        send_draw(MODE_RAW, 32'd0);
        drain();
        write_reg(REG_TABLE_SEED_INDEX, 31'h7FFF_FF80);
        send_draw(MODE_BOUNDED, 32'd7);
        drain();
        write_reg(REG_USE_TABLE_SEED, 31'h7FFF_FFFE);
        send_draw(MODE_RAW, 32'd0);
        drain();
        write_reg(REG_USE_TABLE_SEED, 31'd1);
        write_reg(REG_TABLE_SEED_INDEX, 31'd0);
        send_draw(MODE_RAW, 32'd0);
        drain();

        // Random phases, each under a fresh register setting.
        for (int phase = 0; phase < 10; phase++)
        begin
            repeat ($urandom_range(1, 3))
                write_reg(2'($urandom_range(0, 3)), pick_reg_data());
            for (int n = 0; n < 100; n++)
            begin
                // Long receiver hold-off while requests keep coming.
                if (phase == 3 && n == 40)
                    hold_req = 1'b1;
                send_draw(($urandom_range(0, 3) == 0) ? MODE_RAW : MODE_BOUNDED,
                          pick_bound());
                if (!(phase == 3 && n >= 40 && n < 55))
                    pace_sender();
            end
            drain();
        end

        // Settle, then report.
        repeat (20) @(posedge clk);
        failures = tracker.mismatches;
        if (tracker.expected_draws.size() != 0)
        begin
            $display("%0d predicted draws never arrived", tracker.expected_draws.size());
            failures++;
        end
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
